// ----- sv/tac_pkg.sv -----
// Package for the tiny accumulator core: request and result types, codes and flag bundle.
`default_nettype none

package tac_pkg;

  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned INSN_W = 16;
  localparam int unsigned IMM_W = 8;

  // Request kinds carried in req_type; the remaining code is ignored.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EXEC  = 2'd1,
    REQ_WRITE = 2'd2
  } tac_req_kind_e;

  // Instruction opcodes; other codes are undefined, set bad_opcode and only advance the PC.
  typedef enum logic [3:0] {
    OP_MOV = 4'd1,
    OP_JMP = 4'd2,
    OP_ADD = 4'd3,
    OP_CMP = 4'd4,
    OP_JLE = 4'd5,
    OP_STO = 4'd6,
    OP_SUB = 4'd7,
    OP_XOR = 4'd8,
    OP_OR  = 4'd9,
    OP_RET = 4'd15
  } tac_op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  load_address;
    logic [15:0] word_value;
    logic [1:0]  target_register;
  } tac_req_t;

  typedef struct packed {
    logic [3:0]  program_counter;
    logic [3:0]  executed_opcode;
    logic        halted;
    logic [15:0] return_value;
    logic        zero_flag;
    logic        carry_flag;
    logic        negative_flag;
    logic        store_valid;
    logic [3:0]  store_address;
    logic [15:0] store_data;
    logic        bad_opcode;
  } tac_rsp_t;

  // Architectural status bits held between instructions.
  typedef struct packed {
    logic halt;
    logic less;
    logic carry;
    logic zero;
  } tac_flags_t;

endpackage

`default_nettype wire

// ----- sv/tac_req_if.sv -----
// Valid/ready channel carrying one request transaction.
`default_nettype none

interface tac_req_if
  import tac_pkg::*;
();
  logic     valid;
  logic     ready;
  tac_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tac_rsp_if.sv -----
// Valid/ready channel carrying one result transaction.
`default_nettype none

interface tac_rsp_if
  import tac_pkg::*;
();
  logic     valid;
  logic     ready;
  tac_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tac_exec.sv -----
// Execute stage: decodes one request against the current state and forms its updates and result.
`default_nettype none

module tac_exec
  import tac_pkg::*;
#(
  parameter int unsigned PROG_DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ADDR_WIDTH = 4
) (
  input  tac_req_t              req_i,
  input  logic [INSN_W-1:0]     insn_i,
  input  logic [ADDR_WIDTH-1:0] pc_i,
  input  tac_flags_t            flags_i,
  input  logic [DATA_WIDTH-1:0] regs_i [NUM_REGS],
  output logic [ADDR_WIDTH-1:0] pc_o,
  output tac_flags_t            flags_o,
  output logic                  rf_we_o,
  output logic [REG_IDX_W-1:0]  rf_idx_o,
  output logic [DATA_WIDTH-1:0] rf_wdata_o,
  output tac_rsp_t              rsp_o
);

  logic [3:0]            op;
  logic [REG_IDX_W-1:0]  x_idx;
  logic [REG_IDX_W-1:0]  y_idx;
  logic [3:0]            tgt;
  logic [IMM_W-1:0]      imm;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH-1:0] mov_val;
  logic [ADDR_WIDTH-1:0] slot;
  logic [3:0]            opcode;
  logic [15:0]           retv;
  logic                  svalid;
  logic [3:0]            saddr;
  logic [15:0]           sdata;
  logic                  bad;

  assign op    = insn_i[3:0];
  assign x_idx = insn_i[5:4];
  assign y_idx = insn_i[7:6];
  assign tgt   = insn_i[7:4];
  assign imm   = insn_i[15:8];
  assign a     = regs_i[x_idx];
  assign b     = regs_i[y_idx];
  assign sum   = {1'b0, a} + {1'b0, b};
  assign slot  = ADDR_WIDTH'(a);

  always_comb begin
    mov_val = regs_i[tgt[1:0]];
    mov_val[IMM_W-1:0] = imm;
  end

  always_comb begin
    pc_o       = pc_i;
    flags_o    = flags_i;
    rf_we_o    = 1'b0;
    rf_idx_o   = req_i.target_register;
    rf_wdata_o = DATA_WIDTH'(req_i.word_value);
    opcode     = '0;
    retv       = '0;
    svalid     = 1'b0;
    saddr      = '0;
    sdata      = '0;
    bad        = 1'b0;

    if (!flags_i.halt) begin
      case (req_i.req_type)
        REQ_WRITE: begin
          rf_we_o = 1'b1;
        end
        REQ_EXEC: begin
          opcode = op;
          pc_o   = pc_i + ADDR_WIDTH'(1);
          case (op)
            OP_MOV: begin
              // Only targets R0 to R3 exist; higher targets are silently dropped.
              if (tgt[3:2] == 2'b00) begin
                rf_we_o    = 1'b1;
                rf_idx_o   = tgt[1:0];
                rf_wdata_o = mov_val;
              end
            end
            OP_JMP: begin
              pc_o = ADDR_WIDTH'(tgt);
            end
            OP_ADD: begin
              rf_we_o       = 1'b1;
              rf_idx_o      = x_idx;
              rf_wdata_o    = sum[DATA_WIDTH-1:0];
              flags_o.carry = sum[DATA_WIDTH];
              flags_o.zero  = (sum[DATA_WIDTH-1:0] == '0);
            end
            OP_CMP: begin
              flags_o.zero = (a == b);
              flags_o.less = (a < b);
            end
            OP_JLE: begin
              if (flags_i.less || flags_i.zero) begin
                pc_o = ADDR_WIDTH'(tgt);
              end
            end
            OP_STO: begin
              if (int'(slot) < int'(PROG_DEPTH)) begin
                svalid = 1'b1;
                saddr  = 4'(slot);
                sdata  = 16'(b);
              end
            end
            OP_SUB: begin
              rf_we_o    = 1'b1;
              rf_idx_o   = x_idx;
              rf_wdata_o = a - b;
            end
            OP_XOR: begin
              rf_we_o    = 1'b1;
              rf_idx_o   = x_idx;
              rf_wdata_o = a ^ b;
            end
            OP_OR: begin
              rf_we_o    = 1'b1;
              rf_idx_o   = x_idx;
              rf_wdata_o = a | b;
            end
            OP_RET: begin
              flags_o.halt = 1'b1;
              retv         = 16'(regs_i[0]);
            end
            default: begin
              bad = 1'b1;
            end
          endcase
        end
        default: begin
          // Loads are handled by the instruction store; the unused code does nothing.
        end
      endcase
    end
  end

  always_comb begin
    rsp_o.program_counter = 4'(pc_o);
    rsp_o.executed_opcode = opcode;
    rsp_o.halted          = flags_o.halt;
    rsp_o.return_value    = retv;
    rsp_o.zero_flag       = flags_o.zero;
    rsp_o.carry_flag      = flags_o.carry;
    rsp_o.negative_flag   = flags_o.less;
    rsp_o.store_valid     = svalid;
    rsp_o.store_address   = saddr;
    rsp_o.store_data      = sdata;
    rsp_o.bad_opcode      = bad;
  end

endmodule

`default_nettype wire

// ----- sv/tiny_accumulator_isa_core.sv -----
// Top level of the tiny accumulator core: input register, state, execute stage, result register.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless rsp_o stalls; the state loop is not pipelined.
// A stalled result register holds the input stage, which then holds back req_i.ready.
// Reset clears the registers, flags, program counter and instruction store at once.
`default_nettype none

module tiny_accumulator_isa_core
  import tac_pkg::*;
#(
  parameter int unsigned PROG_DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ADDR_WIDTH = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  tac_req_if.sink    req_i,
  tac_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(PROG_DEPTH);

  logic                  stg_valid_q;
  tac_req_t              stg_req_q;
  logic                  out_valid_q;
  tac_rsp_t              out_q;
  logic                  adv;

  logic [INSN_W-1:0]     imem_q [PROG_DEPTH];
  logic [DATA_WIDTH-1:0] regs_q [NUM_REGS];
  logic [ADDR_WIDTH-1:0] pc_q;
  logic [ADDR_WIDTH-1:0] pc_d;
  tac_flags_t            flags_q;
  tac_flags_t            flags_d;

  logic [INSN_W-1:0]     insn;
  logic [IDX_W-1:0]      fetch_idx;
  logic [IDX_W-1:0]      load_idx;
  logic                  load_en;
  logic                  rf_we;
  logic [REG_IDX_W-1:0]  rf_idx;
  logic [DATA_WIDTH-1:0] rf_wdata;
  tac_rsp_t              rsp_d;

  assign adv         = stg_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !stg_valid_q || adv;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Slots at or beyond the store depth fetch as zero.
  assign fetch_idx = IDX_W'(pc_q);
  assign insn      = (int'(pc_q) < int'(PROG_DEPTH)) ? imem_q[fetch_idx] : '0;
  assign load_idx  = IDX_W'(stg_req_q.load_address);
  assign load_en   = adv && !flags_q.halt && (stg_req_q.req_type == REQ_LOAD) &&
                     (int'(stg_req_q.load_address) < int'(PROG_DEPTH));

  tac_exec #(
    .PROG_DEPTH (PROG_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_exec (
    .req_i      (stg_req_q),
    .insn_i     (insn),
    .pc_i       (pc_q),
    .flags_i    (flags_q),
    .regs_i     (regs_q),
    .pc_o       (pc_d),
    .flags_o    (flags_d),
    .rf_we_o    (rf_we),
    .rf_idx_o   (rf_idx),
    .rf_wdata_o (rf_wdata),
    .rsp_o      (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      stg_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      stg_req_q <= req_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      flags_q <= '0;
    end else if (adv) begin
      pc_q    <= pc_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_REGS); i++) begin
        regs_q[i] <= '0;
      end
    end else if (adv && rf_we) begin
      regs_q[rf_idx] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(PROG_DEPTH); i++) begin
        imem_q[i] <= '0;
      end
    end else if (load_en) begin
      imem_q[load_idx] <= stg_req_q.word_value;
    end
  end

  // Once the core has halted it stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.halt |=> flags_q.halt)
    else $error("halt flag cleared after ret");

  // A halted core leaves the program counter where it stopped.
  a_halt_pc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q.halt && adv) |=> (pc_q == $past(pc_q)))
    else $error("program counter moved while halted");

  // Only sto may report a data store write.
  a_store_only_sto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.store_valid) |-> (out_q.executed_opcode == OP_STO))
    else $error("store reported for an instruction other than sto");

  // A non-zero return value only accompanies the ret that halted the core.
  a_retv_on_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.return_value != '0)) |->
      (out_q.halted && (out_q.executed_opcode == OP_RET)))
    else $error("return value reported without ret");

  // A request that executes nothing leaves the program counter alone.
  a_pc_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (stg_req_q.req_type != REQ_EXEC)) |=> (pc_q == $past(pc_q)))
    else $error("program counter moved on a non-execute request");

endmodule

`default_nettype wire

// ----- sim/tac_exec_checker.sv -----
// Checker for the tiny accumulator core: predicts each result transaction and compares it.
`timescale 1ns / 100ps

module tac_exec_checker
  import tac_pkg::*;
(
  input  wire clk_i,
  input  wire rst_ni,
  tac_req_if  req_mon,
  tac_rsp_if  rsp_mon,
  output int  faults_o,
  output int  waiting_o,
  output int  results_o,
  output int  stores_o,
  output int  jumps_o,
  output int  undef_ops_o
);

  localparam int unsigned SLOTS = 16;
  localparam int unsigned REPORT_MAX = 10;

  logic [INSN_W-1:0] insn_mem [SLOTS];
  logic [15:0]       data_mem [SLOTS];
  logic [15:0]       core_regs [NUM_REGS];
  logic [3:0]        pc_q;
  tac_flags_t        flags_q;
  tac_rsp_t          predicted_rsp_q [$];
  tac_rsp_t          oldest_rsp;

  // Applies one request to the shadow core and returns the result it should produce.
  function automatic tac_rsp_t step_core(input tac_req_t item);
    tac_rsp_t          res;
    logic [INSN_W-1:0] ir;
    logic [3:0]        op;
    logic [1:0]        rx;
    logic [1:0]        ry;
    logic [3:0]        tgt;
    logic [15:0]       a;
    logic [15:0]       b;
    logic [16:0]       sum;

    res = '0;
    if (!flags_q.halt) begin
      case (item.req_type)
        REQ_LOAD: begin
          insn_mem[item.load_address] = item.word_value;
        end
        REQ_WRITE: begin
          core_regs[item.target_register] = item.word_value;
        end
        REQ_EXEC: begin
          ir  = insn_mem[pc_q];
          op  = ir[3:0];
          rx  = ir[5:4];
          ry  = ir[7:6];
          tgt = ir[7:4];
          a   = core_regs[rx];
          b   = core_regs[ry];
          res.executed_opcode = op;
          pc_q = pc_q + 4'd1;
          case (op)
            OP_MOV: begin
              if (tgt < NUM_REGS)
                core_regs[tgt[1:0]] = {core_regs[tgt[1:0]][15:8], ir[15:8]};
            end
            OP_JMP: begin
              pc_q = tgt;
              jumps_o++;
            end
            OP_ADD: begin
              sum = {1'b0, a} + {1'b0, b};
              flags_q.carry = sum[16];
              flags_q.zero = (sum[15:0] == 16'h0000);
              core_regs[rx] = sum[15:0];
            end
            OP_CMP: begin
              flags_q.zero = (a == b);
              flags_q.less = (a < b);
            end
            OP_JLE: begin
              if (flags_q.less || flags_q.zero) begin
                pc_q = tgt;
                jumps_o++;
              end
            end
            OP_STO: begin
              data_mem[a[3:0]] = b;
              res.store_valid = 1'b1;
              res.store_address = a[3:0];
              res.store_data = b;
              stores_o++;
            end
            OP_SUB: core_regs[rx] = a - b;
            OP_XOR: core_regs[rx] = a ^ b;
            OP_OR:  core_regs[rx] = a | b;
            OP_RET: begin
              flags_q.halt = 1'b1;
              res.return_value = core_regs[0];
            end
            default: begin
              res.bad_opcode = 1'b1;
              undef_ops_o++;
            end
          endcase
        end
        default: ;
      endcase
    end
    res.program_counter = pc_q;
    res.halted = flags_q.halt;
    res.zero_flag = flags_q.zero;
    res.carry_flag = flags_q.carry;
    res.negative_flag = flags_q.less;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      faults_o++;
      if (faults_o <= REPORT_MAX)
        $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        insn_mem[i] = '0;
        data_mem[i] = '0;
      end
      for (int i = 0; i < NUM_REGS; i++) core_regs[i] = '0;
      pc_q = '0;
      flags_q = '0;
      predicted_rsp_q.delete();
      waiting_o = 0;
    end else begin
      // The result transaction at this edge always belongs to an older request.
      if (rsp_mon.valid && rsp_mon.ready) begin
        results_o++;
        if (predicted_rsp_q.size() == 0) begin
          faults_o++;
          if (faults_o <= REPORT_MAX)
            $display("%0t: result transaction with nothing expected", $time);
        end else begin
          oldest_rsp = predicted_rsp_q.pop_front();
          check_field("program_counter", 16'(oldest_rsp.program_counter),
                      16'(rsp_mon.data.program_counter));
          check_field("executed_opcode", 16'(oldest_rsp.executed_opcode),
                      16'(rsp_mon.data.executed_opcode));
          check_field("halted", 16'(oldest_rsp.halted), 16'(rsp_mon.data.halted));
          check_field("return_value", oldest_rsp.return_value, rsp_mon.data.return_value);
          check_field("zero_flag", 16'(oldest_rsp.zero_flag), 16'(rsp_mon.data.zero_flag));
          check_field("carry_flag", 16'(oldest_rsp.carry_flag), 16'(rsp_mon.data.carry_flag));
          check_field("negative_flag", 16'(oldest_rsp.negative_flag),
                      16'(rsp_mon.data.negative_flag));
          check_field("store_valid", 16'(oldest_rsp.store_valid),
                      16'(rsp_mon.data.store_valid));
          check_field("store_address", 16'(oldest_rsp.store_address),
                      16'(rsp_mon.data.store_address));
          check_field("store_data", oldest_rsp.store_data, rsp_mon.data.store_data);
          check_field("bad_opcode", 16'(oldest_rsp.bad_opcode), 16'(rsp_mon.data.bad_opcode));
        end
      end
      if (req_mon.valid && req_mon.ready)
        predicted_rsp_q.push_back(step_core(req_mon.data));
      waiting_o = predicted_rsp_q.size();
    end
  end

endmodule

// ----- sim/tiny_accumulator_isa_core_test.sv -----
// Testbench top for the tiny accumulator core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tiny_accumulator_isa_core_test;
  import tac_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [3:0] OP_UNDEF_ZERO = 4'd0;
  localparam logic [3:0] OP_UNDEF_LO = 4'd10;
  localparam logic [3:0] OP_UNDEF_HI = 4'd14;
  localparam logic [1:0] REG_R0 = 2'd0;
  localparam logic [1:0] REG_R1 = 2'd1;
  localparam logic [1:0] REG_R2 = 2'd2;
  localparam logic [1:0] REG_R3 = 2'd3;
  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 1350;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic clk_i;
  logic rst_ni;
  int   faults;
  int   waiting;
  int   results;
  int   stores;
  int   jumps;
  int   undef_ops;
  int   loads_sent = 0;
  int   execs_sent = 0;
  int   writes_sent = 0;
  int   ignored_sent = 0;
  int   send_burst = 0;
  int   ready_burst = 0;
  int   stall_left = 0;
  int   idle_cycles;

  tac_req_if req_if ();
  tac_rsp_if rsp_if ();

  tiny_accumulator_isa_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tac_exec_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .faults_o    (faults),
    .waiting_o   (waiting),
    .results_o   (results),
    .stores_o    (stores),
    .jumps_o     (jumps),
    .undef_ops_o (undef_ops)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short pauses, a few long ones, and now and then a stretch with none at all.
  function automatic int pause_len(inout int burst);
    int pick;
    pick = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (pick < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] insn(input logic [3:0] op, input logic [3:0] field,
                                       input logic [7:0] imm);
    return {imm, field, op};
  endfunction

  // Never yields a return instruction, so the core keeps running until the final phase.
  function automatic logic [15:0] rand_insn();
    logic [3:0] op;
    logic [3:0] field;
    int         pick;
    pick = $urandom_range(0, 99);
    field = 4'($urandom_range(0, 15));
    if (pick < 15) begin
      op = OP_MOV;
      if ($urandom_range(0, 4) != 0) field[3:2] = 2'b00;
    end else if (pick < 20) op = OP_JMP;
    else if (pick < 35) op = OP_ADD;
    else if (pick < 47) op = OP_CMP;
    else if (pick < 59) op = OP_JLE;
    else if (pick < 69) op = OP_STO;
    else if (pick < 79) op = OP_SUB;
    else if (pick < 87) op = OP_XOR;
    else if (pick < 95) op = OP_OR;
    else if (pick < 97) op = OP_UNDEF_ZERO;
    else op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    return insn(op, field, 8'($urandom_range(0, 255)));
  endfunction

  // Edge values are favoured so that sums wrap to zero and compares find equality.
  function automatic logic [15:0] reg_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'($urandom_range(0, 15));
      4: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send(input logic [1:0] kind, input logic [3:0] slot, input logic [15:0] word,
                      input logic [1:0] dst);
    tac_req_t item;
    int       gap;
    item.req_type = kind;
    item.load_address = slot;
    item.word_value = word;
    item.target_register = dst;
    req_if.data <= item;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (kind)
      REQ_LOAD:  loads_sent++;
      REQ_EXEC:  execs_sent++;
      REQ_WRITE: writes_sent++;
      default:   ignored_sent++;
    endcase
    @(negedge clk_i);
    gap = pause_len(send_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic load(input logic [3:0] slot, input logic [15:0] word);
    send(REQ_LOAD, slot, word, 2'($urandom_range(0, 3)));
  endtask

  task automatic exec();
    send(REQ_EXEC, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
         2'($urandom_range(0, 3)));
  endtask

  task automatic write_reg(input logic [1:0] dst, input logic [15:0] value);
    send(REQ_WRITE, 4'($urandom_range(0, 15)), value, dst);
  endtask

  // Always waits for a falling edge, and until nothing is outstanding, so the next transaction starts in a fresh step.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = pause_len(ready_burst);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tiny_accumulator_isa_core test failed");
    $finish;
  end

  initial begin
    int         target;
    int         pick;
    logic [1:0] kind;
    logic [15:0] word;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Slot 0 is still clear after reset, so this executes an undefined opcode.
    exec();
    send(REQ_UNUSED, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
         2'($urandom_range(0, 3)));
    write_reg(REG_R0, 16'hFFFF);
    write_reg(REG_R1, 16'h0001);
    write_reg(REG_R2, 16'h8000);
    load(4'd1, insn(OP_ADD, {REG_R1, REG_R0}, 8'h00));
    load(4'd2, insn(OP_CMP, {REG_R2, REG_R1}, 8'h5A));
    load(4'd3, insn(OP_JLE, 4'd5, 8'h00));
    load(4'd5, insn(OP_MOV, {2'b00, REG_R3}, 8'hFF));
    load(4'd6, insn(OP_MOV, 4'd7, 8'hAA));
    load(4'd7, insn(OP_SUB, {REG_R1, REG_R0}, 8'h00));
    load(4'd8, insn(OP_STO, {REG_R2, REG_R3}, 8'h00));
    load(4'd9, insn(OP_JMP, 4'd15, 8'hC3));
    load(4'd15, insn(OP_UNDEF_HI, 4'hF, 8'hFF));
    // Carry out to zero, a taken jle, a mov to a missing register, a wrapping sub, a store,
    // a jump to the top slot and the program counter wrapping back to slot 0.
    repeat (10) exec();

    drain();
    target = loads_sent + execs_sent + writes_sent + RANDOM_ITEMS;
    while (loads_sent + execs_sent + writes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        drain();
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 4)) begin
          kind = 2'($urandom_range(0, 3));
          word = 16'($urandom_range(0, 16'hFFFF));
          if (kind == REQ_LOAD && word[3:0] == OP_RET) word[3:0] = OP_UNDEF_HI;
          send(kind, 4'($urandom_range(0, 15)), word, 2'($urandom_range(0, 3)));
        end
      end else begin
        repeat ($urandom_range(2, 16)) load(4'($urandom_range(0, 15)), rand_insn());
        if ($urandom_range(0, 1) != 0)
          repeat ($urandom_range(1, 4)) write_reg(2'($urandom_range(0, 3)), reg_value());
        repeat ($urandom_range(4, 24)) begin
          if ($urandom_range(0, 9) == 0) write_reg(2'($urandom_range(0, 3)), reg_value());
          exec();
        end
      end
    end

    // Fill every slot with ret so the next execution halts wherever the counter points.
    write_reg(REG_R0, reg_value());
    for (int slot = 0; slot < SLOTS; slot++)
      load(slot[3:0], insn(OP_RET, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    exec();
    load(4'd0, rand_insn());
    write_reg(REG_R1, 16'h1234);
    exec();
    send(REQ_UNUSED, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
         2'($urandom_range(0, 3)));
    exec();

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Sent %0d loads, %0d executes, %0d register writes and %0d unknown requests.",
             loads_sent, execs_sent, writes_sent, ignored_sent);
    $display("Checked %0d results: %0d stores, %0d jumps taken, %0d undefined opcodes.",
             results, stores, jumps, undef_ops);
    if (faults == 0 && waiting == 0)
      $display("tiny_accumulator_isa_core test passed");
    else
      $display("tiny_accumulator_isa_core test failed");
    $finish;
  end

endmodule
